@@ rtl/spmq_pkg.sv @@
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared constants, codes and types of the strict-priority multi-queue unit.
// ----------------------------------------------------------------------------
package spmq_pkg;

    localparam int LEVELS      = 3;
    localparam int QUEUE_DEPTH = 128;
    localparam int DATA_WIDTH  = 32;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    localparam int REQ_TYPE_W = 1;
    localparam int PRIO_W     = 2;
    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_PUSH_DROP = 2'd1,
        STATUS_POP_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic                pop_hit;
        logic [PRIO_W-1:0]   level;
        status_t             status;
    } spmq_op_t;

endpackage

@@ rtl/spmq_in_if.sv @@
// ----------------------------------------------------------------------------
// spmq_in_if
// Request channel: one push or pop beat per valid/ready handshake.
// ----------------------------------------------------------------------------
interface spmq_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  req_type;
    logic [1:0]  priority_req;
    logic [31:0] data_in;

    modport source (output valid, output req_type, output priority_req,
                    output data_in, input ready);
    modport sink (input valid, input req_type, input priority_req,
                  input data_in, output ready);
endinterface

@@ rtl/spmq_out_if.sv @@
// ----------------------------------------------------------------------------
// spmq_out_if
// Result channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface spmq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_out;
    logic        valid_res;
    logic [1:0]  level_out;
    logic [1:0]  status;

    modport source (output valid, output data_out, output valid_res,
                    output level_out, output status, input ready);
    modport sink (input valid, input data_out, input valid_res,
                  input level_out, input status, output ready);
endinterface

@@ rtl/strict_priority_multi_queue_unit.sv @@
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit
// Strict-priority multi-level FIFO: pushes append to the queue of their
// level, pops take the oldest word of the lowest-numbered non-empty level.
//
//   Channel   Role     Beat contents
//   cmd       sink     req_type, priority_req, data_in
//   res       source   data_out, valid_res, level_out, status
//
// Each request issues its memory access when it is accepted, the registered
// read is captured in the result register in ST_FETCH and the result is held
// in ST_HOLD; a new request is taken only while idle or as the held result is
// taken, so the unit never takes a new request before the last one is through.
// Reset empties all queues; the memory contents are not cleared.
// A stalled result holds the unit until it is taken.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_unit (
    input  logic       clk,
    input  logic       rst_n,
    spmq_in_if.sink    cmd,
    spmq_out_if.source res
);
    import spmq_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    spmq_op_t               op;
    logic                   accept;
    logic [DATA_WIDTH-1:0]  ram_rdata;

    logic                   hit_reg;
    logic [PRIO_W-1:0]      level_reg;
    status_t                status_reg;
    logic [FIELD_W-1:0]     data_reg;

    assign accept = cmd.valid && cmd.ready;

    spmq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (cmd.req_type),
        .priority_req (cmd.priority_req),
        .op           (op)
    );

    spmq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_queue_store (
        .clk   (clk),
        .we    (accept && op.we),
        .addr  (op.addr),
        .wdata (DATA_WIDTH'(cmd.data_in)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (accept)
                begin
                    state_next = ST_FETCH;
                end
                else if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE) || ((state_reg == ST_HOLD) && res.ready);
        res.valid = (state_reg == ST_HOLD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg    <= op.pop_hit;
            level_reg  <= op.level;
            status_reg <= op.status;
        end
        if (state_reg == ST_FETCH)
        begin
            data_reg <= hit_reg ? FIELD_W'(ram_rdata) : '0;
        end
    end

    assign res.data_out  = data_reg;
    assign res.valid_res = hit_reg;
    assign res.level_out = level_reg;
    assign res.status    = status_reg;

endmodule

@@ rtl/spmq_ram.sv @@
// ----------------------------------------------------------------------------
// spmq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module spmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/spmq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spmq_ctrl
// Per-level head, tail and occupancy registers, priority pick and the
// memory operation for each accepted request.
// ----------------------------------------------------------------------------
module spmq_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [spmq_pkg::REQ_TYPE_W-1:0]   req_type,
    input  logic [spmq_pkg::PRIO_W-1:0]       priority_req,
    output spmq_pkg::spmq_op_t                op
);
    import spmq_pkg::*;

    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0] occ_reg [LEVELS];
    logic [CNT_W-1:0] occ_next [LEVELS];

    logic             hit_found;
    logic [LVL_W-1:0] hit_q;
    logic [LVL_W-1:0] push_q;
    logic             prio_ok;
    logic             push_ok;

    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(QUEUE_DEPTH);

    always_comb
    begin
        hit_found = 1'b0;
        hit_q     = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!hit_found && (occ_reg[i] != '0))
            begin
                hit_found = 1'b1;
                hit_q     = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        push_q  = LVL_W'(priority_req) - LVL_W'(1);
        prio_ok = (priority_req != '0) && (32'(priority_req) <= LEVELS);
        push_ok = prio_ok && (occ_reg[push_q] != FULL_CNT);
    end

    always_comb
    begin
        op = '0;
        if (req_type == REQ_PUSH)
        begin
            op.we     = push_ok;
            op.addr   = ADDR_W'(push_q) * ROW_SIZE + ADDR_W'(tail_reg[push_q]);
            op.status = push_ok ? STATUS_OK : STATUS_PUSH_DROP;
        end
        else
        begin
            op.addr    = ADDR_W'(hit_q) * ROW_SIZE + ADDR_W'(head_reg[hit_q]);
            op.pop_hit = hit_found;
            op.level   = hit_found ? PRIO_W'(32'(hit_q) + 1) : '0;
            op.status  = hit_found ? STATUS_OK : STATUS_POP_EMPTY;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (accept)
        begin
            if ((req_type == REQ_PUSH) && push_ok)
            begin
                tail_next[push_q] = (tail_reg[push_q] == LAST_SLOT) ? '0
                                    : tail_reg[push_q] + PTR_W'(1);
                occ_next[push_q]  = occ_reg[push_q] + CNT_W'(1);
            end
            else if ((req_type == REQ_POP) && hit_found)
            begin
                head_next[hit_q] = (head_reg[hit_q] == LAST_SLOT) ? '0
                                   : head_reg[hit_q] + PTR_W'(1);
                occ_next[hit_q]  = occ_reg[hit_q] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

endmodule
